// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
// Needs clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/mbsw_pkg.sv =====
// Shared types, mark codes and helper functions for the maze walker.
// No dependencies.
`timescale 1ns / 1ps

package mbsw_pkg;

	typedef enum logic [1:0] {PH_IDLE, PH_BUILD, PH_SOLVE, PH_WAIT} phase_t;
	typedef enum logic [1:0] {ST_OK, ST_REFUSED, ST_READ} status_t;

	localparam logic [6:0] MK_VIS    = 7'h01;
	localparam logic [6:0] MK_TOP    = 7'h02;
	localparam logic [6:0] MK_RIGHT  = 7'h04;
	localparam logic [6:0] MK_BOTTOM = 7'h08;
	localparam logic [6:0] MK_LEFT   = 7'h10;
	localparam logic [6:0] MK_SOLVED = 7'h20;
	localparam logic [6:0] MK_PATH   = 7'h40;
	localparam logic [6:0] MK_WALLS  = 7'h1E;

	typedef struct packed {
		logic        req_type;
		logic [15:0] rand_value;
		logic [11:0] new_start;
		logic [11:0] new_end;
		logic [11:0] read_cell;
	} item_t;

	typedef struct packed {
		status_t     status;
		phase_t      phase;
		logic [11:0] head_cell;
		logic [11:0] changed_cell;
		logic [6:0]  changed_marks;
		logic [11:0] partner_cell;
		logic [6:0]  partner_marks;
		logic        partner_valid;
		logic [6:0]  read_marks;
	} res_t;

	// wall on the current cell facing direction d (top, right, bottom, left)
	function automatic logic [6:0] own_wall(input logic [1:0] d);
		case (d)
			2'd0: own_wall = MK_TOP;
			2'd1: own_wall = MK_RIGHT;
			2'd2: own_wall = MK_BOTTOM;
			default: own_wall = MK_LEFT;
		endcase
	endfunction

	// wall on the neighbor facing back
	function automatic logic [6:0] far_wall(input logic [1:0] d);
		case (d)
			2'd0: far_wall = MK_BOTTOM;
			2'd1: far_wall = MK_LEFT;
			2'd2: far_wall = MK_TOP;
			default: far_wall = MK_RIGHT;
		endcase
	endfunction

endpackage

// ===== rtl/core/mbsw_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module mbsw_div #(
	parameter int DW = 16,
	parameter int VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dvd,
	input  logic [VW-1:0] dvs,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [VW-1:0] rem
);

	localparam int CNW = $clog2(DW + 1);

	logic [DW-1:0]  a_q;
	logic [VW-1:0]  r_q;
	logic [VW-1:0]  d_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [VW:0]    trial;
	logic           ge;
	logic [VW-1:0]  nr;

	always_comb begin
		trial = {r_q, a_q[DW-1]};
		ge    = trial >= {1'b0, d_q};
		nr    = ge ? VW'(trial - {1'b0, d_q}) : VW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dvd;
			r_q <= '0;
			d_q <= dvs;
		end else if (busy_q) begin
			a_q <= {a_q[DW-2:0], ge};
			r_q <= nr;
		end
	end

	assign done = done_q;
	assign quo  = a_q;
	assign rem  = r_q;

endmodule

// ===== rtl/core/mbsw_seq.sv =====
// Step sequencer: grid and stack memories, build and solve steps.
// Depends on mbsw_pkg and mbsw_div.
`timescale 1ns / 1ps

module mbsw_seq #(
	parameter int MAX_SIDE = 64,
	localparam int SW = $clog2(MAX_SIDE + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  mbsw_pkg::item_t      item,
	output logic                 idle,
	input  logic [SW-1:0]        cols,
	input  logic [SW-1:0]        rows,
	input  logic [7:0]           ticks,
	input  logic                 geo_wr,
	output mbsw_pkg::res_t       res,
	output logic                 res_valid,
	input  logic                 res_ready
);
	import mbsw_pkg::*;

	localparam int CAP  = MAX_SIDE * MAX_SIDE;
	localparam int CW   = $clog2(CAP);
	localparam int DPW  = CW + 1;
	localparam int NW   = 2 * SW;
	localparam int DW   = (CW > 16) ? CW : 16;
	localparam int VW   = (SW > 3) ? SW : 3;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RDW, S_RDC, S_BW, S_BC, S_SW, S_SC, S_DIVC,
		S_CURW, S_CURC, S_NBA, S_NBW, S_NBC, S_EVAL, S_DIVK, S_KW2,
		S_SENT, S_SEW, S_SEC, S_HEAD, S_HEADW, S_HEADC, S_OUT
	} state_t;

	state_t         state_q;
	phase_t         phase_q;
	logic [CW-1:0]  start_q, end_q, cur_q, nx_q;
	logic [DPW-1:0] bdep_q, sdep_q, clr_q;
	logic [7:0]     wcnt_q;
	logic           newmaze_q;
	logic [15:0]    rand_q;
	logic [SW-1:0]  cx_q, cy_q;
	logic [6:0]     curm_q;
	logic [3:0][6:0] nbm_q;
	logic [3:0]     nbok_q;
	logic [1:0]     dir_q;
	res_t           res_q;

	logic           g_we_q, b_we_q, s_we_q;
	logic [CW-1:0]  g_wa_q, g_ra_q, b_wa_q, b_ra_q, s_wa_q, s_ra_q;
	logic [6:0]     g_wd_q, g_rd_q;
	logic [CW-1:0]  b_wd_q, b_rd_q, s_wd_q, s_rd_q;
	logic [6:0]     grid_mem [CAP];
	logic [CW-1:0]  bstk_mem [CAP];
	logic [CW-1:0]  sstk_mem [CAP];

	logic           div_go_q;
	logic [DW-1:0]  div_dvd_q;
	logic [VW-1:0]  div_dvs_q;
	logic           div_done;
	logic [DW-1:0]  div_quo;
	logic [VW-1:0]  div_rem;

	logic [NW-1:0]   n;
	logic [3:0][CW-1:0] na;
	logic [3:0]     ex;
	logic [3:0]     bc, sc;
	logic [2:0]     bcnt, seen;
	logic [1:0]     bsel, ssel, kval;
	logic           sfound;

	mbsw_div #(.DW(DW), .VW(VW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .dvd(div_dvd_q),
		.dvs(div_dvs_q), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	always_ff @(posedge clk) begin
		if (g_we_q)
			grid_mem[g_wa_q] <= g_wd_q;
		g_rd_q <= grid_mem[g_ra_q];
	end

	always_ff @(posedge clk) begin
		if (b_we_q)
			bstk_mem[b_wa_q] <= b_wd_q;
		b_rd_q <= bstk_mem[b_ra_q];
	end

	always_ff @(posedge clk) begin
		if (s_we_q)
			sstk_mem[s_wa_q] <= s_wd_q;
		s_rd_q <= sstk_mem[s_ra_q];
	end

	always_comb begin
		n     = NW'(cols) * NW'(rows);
		na[0] = cur_q - CW'(cols);
		na[1] = cur_q + CW'(1);
		na[2] = cur_q + CW'(cols);
		na[3] = cur_q - CW'(1);
		ex[0] = cy_q != '0;
		ex[1] = ((SW+1)'(cx_q) + (SW+1)'(1)) < (SW+1)'(cols);
		ex[2] = ((SW+1)'(cy_q) + (SW+1)'(1)) < (SW+1)'(rows);
		ex[3] = cx_q != '0;
	end

	always_comb begin
		kval   = 2'(div_rem);
		bsel   = 2'd0;
		ssel   = 2'd0;
		seen   = 3'd0;
		for (int d = 0; d < 4; d++) begin
			bc[d] = nbok_q[d] && !nbm_q[d][0];
			sc[d] = nbok_q[d] && ((curm_q & own_wall(2'(d))) == '0)
				&& ((nbm_q[d] & MK_SOLVED) == '0);
		end
		bcnt = 3'($countones(bc));
		for (int d = 0; d < 4; d++) begin
			if (bc[d]) begin
				if (seen == {1'b0, kval})
					bsel = 2'(d);
				seen = seen + 3'd1;
			end
		end
		for (int d = 3; d >= 0; d--) begin
			if (sc[d])
				ssel = 2'(d);
		end
		sfound = |sc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			phase_q   <= PH_IDLE;
			start_q   <= '0;
			end_q     <= '0;
			bdep_q    <= '0;
			sdep_q    <= '0;
			wcnt_q    <= '0;
			clr_q     <= '0;
			newmaze_q <= 1'b0;
			g_we_q    <= 1'b0;
			b_we_q    <= 1'b0;
			s_we_q    <= 1'b0;
			div_go_q  <= 1'b0;
		end else begin
			g_we_q   <= 1'b0;
			b_we_q   <= 1'b0;
			s_we_q   <= 1'b0;
			div_go_q <= 1'b0;
			if (geo_wr)
				phase_q <= PH_IDLE;
			case (state_q)
				S_CLR: begin
					g_we_q <= 1'b1;
					g_wa_q <= CW'(clr_q);
					g_wd_q <= MK_WALLS;
					clr_q  <= clr_q + DPW'(1);
					if (clr_q == DPW'(CAP - 1))
						state_q <= newmaze_q ? S_SENT : S_IDLE;
				end
				S_IDLE: begin
					if (in_fire) begin
						res_q         <= '0;
						rand_q        <= item.rand_value;
						res_q.status  <= ST_OK;
						state_q       <= S_HEAD;
						if (item.req_type) begin
							res_q.status <= ST_READ;
							if (32'(item.read_cell) < 32'(n)) begin
								g_ra_q  <= CW'(item.read_cell);
								state_q <= S_RDW;
							end
						end else begin
							case (phase_q)
								PH_IDLE: begin
									if (32'(item.new_start) >= 32'(n)
										|| 32'(item.new_end) >= 32'(n)
										|| item.new_start == item.new_end) begin
										res_q.status <= ST_REFUSED;
									end else begin
										start_q   <= CW'(item.new_start);
										end_q     <= CW'(item.new_end);
										b_we_q    <= 1'b1;
										b_wa_q    <= '0;
										b_wd_q    <= CW'(item.new_start);
										bdep_q    <= DPW'(1);
										sdep_q    <= '0;
										wcnt_q    <= '0;
										phase_q   <= PH_BUILD;
										res_q.changed_cell  <= item.new_start;
										res_q.changed_marks <= MK_WALLS | MK_VIS;
										newmaze_q <= 1'b1;
										clr_q     <= '0;
										state_q   <= S_CLR;
									end
								end
								PH_BUILD: begin
									if (bdep_q != '0) begin
										b_ra_q  <= CW'(bdep_q - DPW'(1));
										state_q <= S_BW;
									end else begin
										state_q <= S_SENT;
									end
								end
								PH_SOLVE: begin
									if (sdep_q == '0) begin
										phase_q <= PH_IDLE;
									end else begin
										s_ra_q  <= CW'(sdep_q - DPW'(1));
										state_q <= S_SW;
									end
								end
								default: begin
									if (wcnt_q <= 8'd1) begin
										wcnt_q  <= '0;
										phase_q <= PH_IDLE;
									end else begin
										wcnt_q <= wcnt_q - 8'd1;
									end
								end
							endcase
						end
					end
				end
				S_RDW: state_q <= S_RDC;
				S_RDC: begin
					res_q.read_marks <= g_rd_q;
					state_q <= S_HEAD;
				end
				S_BW: state_q <= S_BC;
				S_BC: begin
					cur_q     <= b_rd_q;
					div_go_q  <= 1'b1;
					div_dvd_q <= DW'(b_rd_q);
					div_dvs_q <= VW'(cols);
					state_q   <= S_DIVC;
				end
				S_SW: state_q <= S_SC;
				S_SC: begin
					cur_q <= s_rd_q;
					if (s_rd_q == end_q) begin
						phase_q <= PH_WAIT;
						wcnt_q  <= ticks;
						state_q <= S_HEAD;
					end else begin
						div_go_q  <= 1'b1;
						div_dvd_q <= DW'(s_rd_q);
						div_dvs_q <= VW'(cols);
						state_q   <= S_DIVC;
					end
				end
				S_DIVC: begin
					if (div_done) begin
						cx_q    <= SW'(div_rem);
						cy_q    <= SW'(div_quo);
						g_ra_q  <= cur_q;
						dir_q   <= 2'd0;
						state_q <= S_CURW;
					end
				end
				S_CURW: state_q <= S_CURC;
				S_CURC: begin
					curm_q  <= g_rd_q;
					state_q <= S_NBA;
				end
				S_NBA: begin
					nbok_q[dir_q] <= ex[dir_q];
					if (ex[dir_q]) begin
						g_ra_q  <= na[dir_q];
						state_q <= S_NBW;
					end else begin
						nbm_q[dir_q] <= '0;
						dir_q   <= dir_q + 2'd1;
						state_q <= (dir_q == 2'd3) ? S_EVAL : S_NBA;
					end
				end
				S_NBW: state_q <= S_NBC;
				S_NBC: begin
					nbm_q[dir_q] <= g_rd_q;
					dir_q   <= dir_q + 2'd1;
					state_q <= (dir_q == 2'd3) ? S_EVAL : S_NBA;
				end
				S_EVAL: begin
					state_q <= S_HEAD;
					if (phase_q == PH_BUILD) begin
						if (bcnt != '0) begin
							div_go_q  <= 1'b1;
							div_dvd_q <= DW'(rand_q);
							div_dvs_q <= VW'(bcnt);
							state_q   <= S_DIVK;
						end else begin
							bdep_q <= bdep_q - DPW'(1);
							if (bdep_q == DPW'(1))
								state_q <= S_SENT;
						end
					end else if (sfound) begin
						g_we_q <= 1'b1;
						g_wa_q <= na[ssel];
						g_wd_q <= nbm_q[ssel] | MK_SOLVED | MK_PATH;
						if (sdep_q < DPW'(CAP)) begin
							s_we_q <= 1'b1;
							s_wa_q <= CW'(sdep_q);
							s_wd_q <= na[ssel];
							sdep_q <= sdep_q + DPW'(1);
						end
						res_q.changed_cell  <= 12'(na[ssel]);
						res_q.changed_marks <= nbm_q[ssel] | MK_SOLVED | MK_PATH;
					end else begin
						g_we_q <= 1'b1;
						g_wa_q <= cur_q;
						g_wd_q <= curm_q & ~MK_PATH;
						sdep_q <= sdep_q - DPW'(1);
						res_q.changed_cell  <= 12'(cur_q);
						res_q.changed_marks <= curm_q & ~MK_PATH;
					end
				end
				S_DIVK: begin
					if (div_done) begin
						dir_q  <= bsel;
						nx_q   <= na[bsel];
						g_we_q <= 1'b1;
						g_wa_q <= cur_q;
						g_wd_q <= curm_q & ~own_wall(bsel);
						if (bdep_q < DPW'(CAP)) begin
							b_we_q <= 1'b1;
							b_wa_q <= CW'(bdep_q);
							b_wd_q <= na[bsel];
							bdep_q <= bdep_q + DPW'(1);
						end
						res_q.changed_cell  <= 12'(cur_q);
						res_q.changed_marks <= curm_q & ~own_wall(bsel);
						res_q.partner_cell  <= 12'(na[bsel]);
						res_q.partner_marks <= (nbm_q[bsel] & ~far_wall(bsel)) | MK_VIS;
						res_q.partner_valid <= 1'b1;
						state_q <= S_KW2;
					end
				end
				S_KW2: begin
					g_we_q  <= 1'b1;
					g_wa_q  <= nx_q;
					g_wd_q  <= (nbm_q[dir_q] & ~far_wall(dir_q)) | MK_VIS;
					state_q <= S_HEAD;
				end
				S_SENT: begin
					if (newmaze_q) begin
						g_we_q    <= 1'b1;
						g_wa_q    <= start_q;
						g_wd_q    <= MK_WALLS | MK_VIS;
						newmaze_q <= 1'b0;
						state_q   <= S_HEAD;
					end else begin
						phase_q <= PH_SOLVE;
						sdep_q  <= DPW'(1);
						s_we_q  <= 1'b1;
						s_wa_q  <= '0;
						s_wd_q  <= start_q;
						g_ra_q  <= start_q;
						state_q <= S_SEW;
					end
				end
				S_SEW: state_q <= S_SEC;
				S_SEC: begin
					g_we_q <= 1'b1;
					g_wa_q <= start_q;
					g_wd_q <= g_rd_q | MK_SOLVED | MK_PATH;
					res_q.changed_cell  <= 12'(start_q);
					res_q.changed_marks <= g_rd_q | MK_SOLVED | MK_PATH;
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					b_ra_q  <= CW'(bdep_q - DPW'(1));
					s_ra_q  <= CW'(sdep_q - DPW'(1));
					state_q <= S_HEADW;
				end
				S_HEADW: state_q <= S_HEADC;
				S_HEADC: begin
					res_q.phase <= phase_q;
					if (phase_q == PH_BUILD && bdep_q != '0)
						res_q.head_cell <= 12'(b_rd_q);
					else if ((phase_q == PH_SOLVE || phase_q == PH_WAIT) && sdep_q != '0)
						res_q.head_cell <= 12'(s_rd_q);
					else
						res_q.head_cell <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_OUT;
	assign res       = res_q;

endmodule

// ===== rtl/core/maze_build_and_solve_walker_unit.sv =====
// Top level: stream ports, configuration registers, output register.
// Depends on mbsw_pkg, mbsw_seq, assert_macros.svh.
`timescale 1ns / 1ps

// Maze builder and solver, one algorithm step per input transaction. After
// reset the grid is swept to walls-up, one cell per cycle over all
// MAX_SIDE*MAX_SIDE cells (4096 by default), with s_axis_tready low. A step
// that starts a new maze sweeps the grid again. A build step that carves
// does a stack read, a pass of the shared divider for the cell coordinates,
// one grid read for the cell and one per neighbor inside the grid, a second
// divider pass for the random pick, two grid writes, then the head-of-stack
// read. A build step that backtracks and a solve step skip the second divider
// pass (when the build stack empties, the solve phase starts with the start
// cell); a solve step that finds the end cell stops after the stack read. A
// read outside the grid skips the grid read. One transaction is in work at a
// time; the result sits in an output register, so the next transaction may
// start while it waits to be taken.
module maze_build_and_solve_walker_unit #(
	parameter int MAX_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// rand_value[15:0], new_start[27:16], new_end[39:28], read_cell[51:40]
	input  logic [55:0] s_axis_tdata,
	// req_type
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// phase[1:0], head_cell[13:2], changed_cell[25:14], changed_marks[32:26],
	// partner_cell[44:33], partner_marks[51:45], partner_valid[52], read_marks[59:53]
	output logic [63:0] m_axis_tdata,
	// status
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mbsw_pkg::*;
	`include "assert_macros.svh"

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_WAIT = 2'd2;

	logic [6:0]    cols_q, rows_q;
	logic [7:0]    wait_q;
	logic [SW-1:0] cols_c, rows_c;
	logic          geo_wr;
	logic          in_fire;
	item_t         item;
	res_t          res, res_q;
	logic          res_valid, res_ready;
	logic          mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 7'd8;
			rows_q <= 7'd8;
			wait_q <= 8'd45;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLS: cols_q <= cfg_data[6:0];
				REG_ROWS: rows_q <= cfg_data[6:0];
				REG_WAIT: wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cols_c = (cols_q < 7'd3) ? SW'(3)
			: ((32'(cols_q) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cols_q));
		rows_c = (rows_q < 7'd3) ? SW'(3)
			: ((32'(rows_q) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(rows_q));
		geo_wr = cfg_we && (cfg_index == REG_COLS || cfg_index == REG_ROWS);
		item.req_type   = s_axis_tuser;
		item.rand_value = s_axis_tdata[15:0];
		item.new_start  = s_axis_tdata[27:16];
		item.new_end    = s_axis_tdata[39:28];
		item.read_cell  = s_axis_tdata[51:40];
	end

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign res_ready = !mv_q || m_axis_tready;

	mbsw_seq #(.MAX_SIDE(MAX_SIDE)) u_seq (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .item(item),
		.idle(s_axis_tready), .cols(cols_c), .rows(rows_c), .ticks(wait_q),
		.geo_wr(geo_wr), .res(res), .res_valid(res_valid), .res_ready(res_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mv_q <= 1'b0;
		else if (res_valid && res_ready)
			mv_q <= 1'b1;
		else if (m_axis_tready)
			mv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			res_q <= res;
	end

	assign m_axis_tvalid = mv_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {4'b0, res_q.read_marks, res_q.partner_valid,
		res_q.partner_marks, res_q.partner_cell, res_q.changed_marks,
		res_q.changed_cell, res_q.head_cell, res_q.phase};

	`AST_NXT(a_busy_after_accept, in_fire, !s_axis_tready)
	`AST_NXT(a_result_loaded, res_valid && res_ready, m_axis_tvalid)
	`AST_IMP(a_refused_idle, m_axis_tvalid && m_axis_tuser == ST_REFUSED, m_axis_tdata[1:0] == PH_IDLE)

endmodule
